@@ sv/dsfb_pkg.sv @@
package dsfb_pkg;

  localparam logic [7:0]  DLE       = 8'h10;
  localparam logic [7:0]  STX       = 8'h02;
  localparam logic [7:0]  ETX       = 8'h03;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] LEN_EXTRA = 16'd10;

  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int CFG_IDX_W  = 8;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_ADDRESS  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_COMMAND = 3'd7;

  // header bytes after the start marker: length hi, length lo, seven regs, command
  localparam int HDR_BYTES = 10;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_HI = 4'd0;
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_LO = 4'd1;
  localparam logic [HDR_IDX_W-1:0] HDR_REG0   = 4'd2;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST   = 4'(HDR_BYTES - 1);

  localparam int QUEUE_DEPTH = 2;

  typedef logic [NUM_REGS-1:0][7:0] hdr_regs_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        no_payload;
    logic        end_of_payload;
    logic        open_frame;
    logic [15:0] len_field;
    logic [7:0]  command;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN_DLE,
    ST_OPEN_STX,
    ST_HDR,
    ST_DATA,
    ST_CRC_HI,
    ST_CRC_LO,
    ST_CLOSE_DLE,
    ST_CLOSE_ETX
  } step_e;

endpackage

@@ sv/dsfb_if.sv @@
interface dsfb_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        no_payload;
  logic        end_of_payload;
  logic [15:0] payload_length;
  logic [7:0]  command_override;

  modport source (output valid, data_byte, no_payload, end_of_payload, payload_length,
                  command_override, input ready);
  modport sink   (input valid, data_byte, no_payload, end_of_payload, payload_length,
                  command_override, output ready);
endinterface

interface dsfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_done;
  logic       run_last;

  modport source (output valid, out_byte, frame_done, run_last, input ready);
  modport sink   (input valid, out_byte, frame_done, run_last, output ready);
endinterface

interface dsfb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dsfb_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/dsfb_queue.sv @@
module dsfb_queue #(
  parameter int DEPTH = dsfb_pkg::QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  dsfb_pkg::q_entry_t         entry_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output dsfb_pkg::q_entry_t         head_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsfb_pkg::q_entry_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ sv/dsfb_front.sv @@
module dsfb_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  dsfb_in_if.sink             in_i,
  dsfb_cfg_if.sink            cfg_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output dsfb_pkg::q_entry_t  q_entry_o,
  output dsfb_pkg::hdr_regs_t regs_o
);

  dsfb_pkg::hdr_regs_t regs_q;
  logic                in_frame_q, in_frame_d;
  logic                accept;
  logic                idle_item;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;
  assign accept      = in_i.valid && in_i.ready;

  // an item inside an open frame that carries nothing and closes nothing is dropped
  assign idle_item = in_frame_q && in_i.no_payload && !in_i.end_of_payload;
  assign q_push_o  = accept && !idle_item;

  always_comb begin
    q_entry_o.data_byte      = in_i.data_byte;
    q_entry_o.no_payload     = in_i.no_payload;
    q_entry_o.end_of_payload = in_i.end_of_payload;
    q_entry_o.open_frame     = !in_frame_q;
    q_entry_o.len_field      = in_i.payload_length + dsfb_pkg::LEN_EXTRA;
    q_entry_o.command        = (in_i.command_override != 8'd0) ? in_i.command_override
                             : regs_q[dsfb_pkg::REG_DEFAULT_COMMAND];
  end

  always_comb begin
    in_frame_d = in_frame_q;
    if (accept) begin
      in_frame_d = !in_i.end_of_payload;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      regs_q     <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      if (cfg_i.valid && cfg_i.ready
          && cfg_i.index < dsfb_pkg::CFG_IDX_W'(dsfb_pkg::NUM_REGS)) begin
        regs_q[cfg_i.index[dsfb_pkg::REG_IDX_W-1:0]] <= cfg_i.data;
      end
    end
  end

endmodule

@@ sv/dsfb_back.sv @@
module dsfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  dsfb_pkg::q_entry_t  head_i,
  input  dsfb_pkg::hdr_regs_t regs_i,
  output logic                pop_o,
  dsfb_out_if.source          out_o
);

  dsfb_pkg::step_e step_q, step_d, eff_step, adv_step, start_step;
  logic [dsfb_pkg::HDR_IDX_W-1:0] hidx_q, hidx_d, adv_hidx;
  logic [dsfb_pkg::REG_IDX_W-1:0] reg_sel;
  logic        dup_q, dup_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, cur_byte, hdr_byte;
  logic        out_done_q, out_last_q;
  logic        stuffable, need_dup, is_last, is_done, emit;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ dsfb_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign emit = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    if (head_i.open_frame) begin
      start_step = dsfb_pkg::ST_OPEN_DLE;
    end else if (!head_i.no_payload) begin
      start_step = dsfb_pkg::ST_DATA;
    end else begin
      start_step = dsfb_pkg::ST_CRC_HI;
    end
    eff_step = (step_q == dsfb_pkg::ST_IDLE) ? start_step : step_q;
  end

  assign reg_sel = 3'(hidx_q - dsfb_pkg::HDR_REG0);

  always_comb begin
    case (hidx_q)
      dsfb_pkg::HDR_LEN_HI: hdr_byte = head_i.len_field[15:8];
      dsfb_pkg::HDR_LEN_LO: hdr_byte = head_i.len_field[7:0];
      dsfb_pkg::HDR_LAST:   hdr_byte = head_i.command;
      default:              hdr_byte = regs_i[reg_sel];
    endcase
  end

  // output decode: byte for the current step and whether it ends the entry
  always_comb begin
    stuffable = 1'b0;
    is_done   = 1'b0;
    unique case (eff_step)
      dsfb_pkg::ST_OPEN_DLE:  cur_byte = dsfb_pkg::DLE;
      dsfb_pkg::ST_OPEN_STX:  cur_byte = dsfb_pkg::STX;
      dsfb_pkg::ST_HDR: begin
        cur_byte  = hdr_byte;
        stuffable = 1'b1;
      end
      dsfb_pkg::ST_DATA: begin
        cur_byte  = head_i.data_byte;
        stuffable = 1'b1;
      end
      dsfb_pkg::ST_CRC_HI: begin
        cur_byte  = crc_q[15:8];
        stuffable = 1'b1;
      end
      dsfb_pkg::ST_CRC_LO: begin
        cur_byte  = crc_q[7:0];
        stuffable = 1'b1;
      end
      dsfb_pkg::ST_CLOSE_DLE: cur_byte = dsfb_pkg::DLE;
      dsfb_pkg::ST_CLOSE_ETX: begin
        cur_byte = dsfb_pkg::ETX;
        is_done  = 1'b1;
      end
      default:                cur_byte = 8'h00;
    endcase
    need_dup = stuffable && (cur_byte == dsfb_pkg::DLE) && !dup_q;
    is_last  = !need_dup && (adv_step == dsfb_pkg::ST_IDLE);
  end

  // sequencing of the steps of one entry
  always_comb begin
    adv_hidx = hidx_q;
    unique case (eff_step)
      dsfb_pkg::ST_OPEN_DLE: adv_step = dsfb_pkg::ST_OPEN_STX;
      dsfb_pkg::ST_OPEN_STX: begin
        adv_step = dsfb_pkg::ST_HDR;
        adv_hidx = dsfb_pkg::HDR_LEN_HI;
      end
      dsfb_pkg::ST_HDR: begin
        if (hidx_q != dsfb_pkg::HDR_LAST) begin
          adv_step = dsfb_pkg::ST_HDR;
          adv_hidx = hidx_q + 1'b1;
        end else if (!head_i.no_payload) begin
          adv_step = dsfb_pkg::ST_DATA;
        end else if (head_i.end_of_payload) begin
          adv_step = dsfb_pkg::ST_CRC_HI;
        end else begin
          adv_step = dsfb_pkg::ST_IDLE;
        end
      end
      dsfb_pkg::ST_DATA:
        adv_step = head_i.end_of_payload ? dsfb_pkg::ST_CRC_HI : dsfb_pkg::ST_IDLE;
      dsfb_pkg::ST_CRC_HI:    adv_step = dsfb_pkg::ST_CRC_LO;
      dsfb_pkg::ST_CRC_LO:    adv_step = dsfb_pkg::ST_CLOSE_DLE;
      dsfb_pkg::ST_CLOSE_DLE: adv_step = dsfb_pkg::ST_CLOSE_ETX;
      default:                adv_step = dsfb_pkg::ST_IDLE;
    endcase

    step_d = step_q;
    hidx_d = hidx_q;
    dup_d  = dup_q;
    crc_d  = crc_q;
    if (emit) begin
      if (need_dup) begin
        step_d = eff_step;
        dup_d  = 1'b1;
      end else begin
        step_d = adv_step;
        hidx_d = adv_hidx;
        dup_d  = 1'b0;
      end
      if (eff_step == dsfb_pkg::ST_OPEN_DLE) begin
        crc_d = 16'h0000;
      end else if ((eff_step == dsfb_pkg::ST_HDR || eff_step == dsfb_pkg::ST_DATA)
                   && !dup_q) begin
        crc_d = crc_feed(crc_q, cur_byte);
      end
    end
    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_o.ready);
  end

  assign pop_o = emit && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= dsfb_pkg::ST_IDLE;
      hidx_q      <= '0;
      dup_q       <= 1'b0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      hidx_q      <= hidx_d;
      dup_q       <= dup_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_byte;
      out_done_q <= is_done;
      out_last_q <= is_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.frame_done = out_done_q;
  assign out_o.run_last   = out_last_q;

endmodule

@@ sv/dle_stuffed_frame_builder.sv @@
// DLE framed packet builder with byte stuffing and CRC-16 (poly 0x1021, init 0).
// in_i: one payload item per transfer. The first item of a frame opens it and
//   supplies payload_length and command_override; end_of_payload closes it.
// out_o: one output byte per transfer, run_last marks the last byte caused by
//   an item, frame_done marks the closing 0x03.
// cfg_i: register writes (index 0..7), always ready; the header's register bytes are
//   read from registers 0..6 while the header goes out. Write only while idle.
// The front tracks frame state and pushes items into a small queue; the back
//   sequences bytes out of the queue head, one byte per cycle while out_o is ready.
// With the queue and the output register empty, an item's first byte is stored
//   in the queue, then in the output register, before it appears on out_o.
//   Throughput: one output byte per cycle while out_o is ready, so a payload item
//   gives one byte, two if it is 0x10; opening a frame adds 12 to 22 bytes and
//   closing it 4 to 6. The output byte rate bounds the item rate.
// A stalled receiver holds the output register; the queue fills and in_i.ready
//   drops when it is full. Idle items inside a frame take no queue slot.
// Reset clears the registers, frame state, CRC, queue and output valid.
module dle_stuffed_frame_builder #(
  parameter int QUEUE_DEPTH = dsfb_pkg::QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dsfb_in_if.sink   in_i,
  dsfb_cfg_if.sink  cfg_i,
  dsfb_out_if.source out_o
);

  dsfb_pkg::q_entry_t  push_entry, head_entry;
  dsfb_pkg::hdr_regs_t regs;
  logic                q_push, q_full, q_pop, q_valid;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  dsfb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .cfg_i     (cfg_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_entry_o (push_entry),
    .regs_o    (regs)
  );

  dsfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (head_entry),
    .valid_o (q_valid),
    .count_o (q_count)
  );

  dsfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (head_entry),
    .regs_i       (regs),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

  a_done_is_last_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.frame_done |-> out_o.run_last && out_o.out_byte == dsfb_pkg::ETX)
    else $error("frame_done not on final ETX byte");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue count overflow");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_count == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("input stalled with queue space");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid && out_o.ready | !out_o.valid)
    else $error("pop without a byte taken");

endmodule
